/* rtl/core/source_layout_feature_counter_core_defines.svh */
// Assertion macros for the source layout feature counter core.
// Included by the RTL files that carry concurrent checks; no other dependencies.
`ifndef SOURCE_LAYOUT_FEATURE_COUNTER_CORE_DEFINES_SVH
`define SOURCE_LAYOUT_FEATURE_COUNTER_CORE_DEFINES_SVH

`ifndef ASSERT_OFF
// Property checked on every rising clk_i edge, skipped while rst_ni is low.
`define SLFC_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("slfc check failed");
// Condition that must never be seen on a rising clk_i edge out of reset.
`define SLFC_ASSERT_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error("slfc forbidden condition seen");
`else
`define SLFC_ASSERT(lbl, prop)
`define SLFC_ASSERT_NEVER(lbl, cond)
`endif

`endif

/* rtl/core/slfc_pkg.sv */
// Shared constants and types for the source layout feature counter.
// No dependencies; used by the core top, front end, queue and back end.
package slfc_pkg;

  // Character codes the front end looks for
  localparam logic [7:0] CHAR_TAB    = 8'h09;
  localparam logic [7:0] CHAR_LF     = 8'h0A;
  localparam logic [7:0] CHAR_CR     = 8'h0D;
  localparam logic [7:0] CHAR_SPACE  = 8'h20;
  localparam logic [7:0] CHAR_LBRACE = 8'h7B;
  // isspace range (tab through CR)
  localparam logic [7:0] WS_LO       = 8'h09;
  localparam logic [7:0] WS_HI       = 8'h0D;

  // Result ratio width and the fraction bits of the whitespace ratio
  localparam int RATIO_W      = 16;
  localparam int WS_FRAC_BITS = 8;

  // Snapshot queue between front and back end
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Queue status seen by both ends
  typedef struct packed {
    logic full;
    logic not_empty;
  } q_status_t;

  // Ratio being divided in the back end
  typedef enum logic [1:0] {
    OP_TAB   = 2'd0,
    OP_SPACE = 2'd1,
    OP_EMPTY = 2'd2,
    OP_WS    = 2'd3
  } op_e;

  // Back end sequencer
  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_DIV  = 3'b010,
    S_HOLD = 3'b100
  } back_state_e;

endpackage

/* rtl/core/slfc_in_if.sv */
// Byte input channel: valid/ready handshake with one text byte per transaction.
// Depends on nothing.
interface slfc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_byte;
  logic       final_byte;

  modport source (output valid, char_byte, final_byte, input ready);
  modport sink   (input valid, char_byte, final_byte, output ready);
endinterface

/* rtl/core/slfc_out_if.sv */
// Result channel: valid/ready handshake, one feature record per transaction.
// Depends on nothing.
interface slfc_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] tab_ratio;
  logic [15:0] space_ratio;
  logic [15:0] empty_line_ratio;
  logic [15:0] whitespace_ratio;
  logic        brace_own_line;
  logic        tab_indent_dominant;

  modport source (output valid, tab_ratio, space_ratio, empty_line_ratio,
                  whitespace_ratio, brace_own_line, tab_indent_dominant,
                  input ready);
  modport sink   (input valid, tab_ratio, space_ratio, empty_line_ratio,
                  whitespace_ratio, brace_own_line, tab_indent_dominant,
                  output ready);
endinterface

/* rtl/core/source_layout_feature_counter_core.sv */
// Source layout feature counter core: byte-rate front end, snapshot queue, divider back end.
// Throughput: one byte per cycle while the snapshot queue has room; the back end works on one
// file at a time and forms one quotient bit per cycle.
// The two-entry queue holds pending files; input stalls only when it is full.
// Reset (rst_ni low, asynchronous) clears all counters, the queue and the result valid.
module source_layout_feature_counter_core #(
  parameter int COUNT_WIDTH   = 24,
  parameter int FRACTION_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  slfc_in_if.sink     in_i,
  slfc_out_if.source  out_o
);

  localparam int SNAP_W = 5 * COUNT_WIDTH + 2;

  slfc_pkg::q_status_t q_stat;
  logic                push;
  logic                pop;
  logic [SNAP_W-1:0]   push_data;
  logic [SNAP_W-1:0]   pop_data;

  // Byte classification and counting
  slfc_front #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .q_stat_i    (q_stat),
    .push_o      (push),
    .push_data_o (push_data)
  );

  // Per-file snapshots awaiting division
  slfc_queue #(
    .W (SNAP_W)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (pop),
    .pop_data_o  (pop_data),
    .stat_o      (q_stat)
  );

  // Ratio division and result register
  slfc_back #(
    .COUNT_WIDTH   (COUNT_WIDTH),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_stat_i   (q_stat),
    .pop_data_i (pop_data),
    .q_pop_o    (pop),
    .out_o      (out_o)
  );

endmodule

/* rtl/core/slfc_front.sv */
// Front end: classifies each byte and updates the saturating layout counters.
// Depends on slfc_pkg and slfc_in_if; pushes a per-file snapshot to slfc_queue.
module slfc_front #(
  parameter int COUNT_WIDTH = 24
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  slfc_in_if.sink                    in_i,
  input  slfc_pkg::q_status_t        q_stat_i,
  output logic                       push_o,
  output logic [5*COUNT_WIDTH+1:0]   push_data_o
);

  localparam int CW = COUNT_WIDTH;

  logic          in_fire;
  logic [7:0]    c;
  logic          is_ws, is_tab, is_space, is_lf, is_cr, is_lbrace;

  logic [CW-1:0] byte_q, byte_d, byte_n;
  logic [CW-1:0] tab_q, tab_d, tab_n;
  logic [CW-1:0] space_q, space_d, space_n;
  logic [CW-1:0] ws_q, ws_d, ws_n;
  logic [CW-1:0] empty_q, empty_d, empty_n;
  logic [CW-1:0] tab_led_q, tab_led_d, tab_led_n;
  logic [CW-1:0] space_led_q, space_led_d, space_led_n;
  logic signed [CW:0] brace_q, brace_d, brace_n;
  logic          blank_q, blank_d, blank_n;
  logic          prior_lf_q, prior_lf_d;
  logic          brace_at_max, brace_at_min;
  logic          brace_pos, tab_dom;

  // Accept a byte whenever the snapshot queue has room
  assign in_i.ready = !q_stat_i.full;
  assign in_fire    = in_i.valid && in_i.ready;
  assign c          = in_i.char_byte;

  // Byte classification
  always_comb begin
    is_ws     = c inside {[slfc_pkg::WS_LO:slfc_pkg::WS_HI], slfc_pkg::CHAR_SPACE};
    is_tab    = (c == slfc_pkg::CHAR_TAB);
    is_space  = (c == slfc_pkg::CHAR_SPACE);
    is_lf     = (c == slfc_pkg::CHAR_LF);
    is_cr     = (c == slfc_pkg::CHAR_CR);
    is_lbrace = (c == slfc_pkg::CHAR_LBRACE);
  end

  // Saturating counter updates: add one unless already all ones
  always_comb begin
    byte_n      = byte_q      + CW'(~&byte_q);
    tab_n       = tab_q       + CW'(is_tab && ~&tab_q);
    space_n     = space_q     + CW'(is_space && ~&space_q);
    ws_n        = ws_q        + CW'(is_ws && ~&ws_q);
    empty_n     = empty_q     + CW'(prior_lf_q && (is_lf || is_cr) && ~&empty_q);
    tab_led_n   = tab_led_q   + CW'(prior_lf_q && is_tab && ~&tab_led_q);
    space_led_n = space_led_q + CW'(prior_lf_q && is_space && ~&space_led_q);
  end

  // Brace balance: up for a brace that opens its line, down otherwise
  always_comb begin
    brace_at_max = (brace_q == {1'b0, {CW{1'b1}}});
    brace_at_min = (brace_q == {1'b1, {CW{1'b0}}});
    brace_n      = brace_q;
    if (is_lbrace) begin
      if (blank_q) begin
        if (!brace_at_max) brace_n = brace_q + (CW+1)'(1);
      end else begin
        if (!brace_at_min) brace_n = brace_q - (CW+1)'(1);
      end
    end
  end

  // Blank-line tracking
  always_comb begin
    if (is_lf) begin
      blank_n = 1'b1;
    end else if (!is_ws) begin
      blank_n = 1'b0;
    end else begin
      blank_n = blank_q;
    end
  end

  // Result flags from the counts that include the last byte
  assign brace_pos = !brace_n[CW] && (brace_n != '0);
  assign tab_dom   = (tab_led_n > space_led_n);

  // Snapshot to the back end on the file's last byte
  assign push_o      = in_fire && in_i.final_byte;
  assign push_data_o = {tab_dom, brace_pos, ws_n, empty_n, space_n, tab_n, byte_n};

  // Next state: advance on each transaction, return to reset after the last byte
  always_comb begin
    byte_d      = byte_q;
    tab_d       = tab_q;
    space_d     = space_q;
    ws_d        = ws_q;
    empty_d     = empty_q;
    tab_led_d   = tab_led_q;
    space_led_d = space_led_q;
    brace_d     = brace_q;
    blank_d     = blank_q;
    prior_lf_d  = prior_lf_q;
    if (in_fire) begin
      if (in_i.final_byte) begin
        byte_d      = '0;
        tab_d       = '0;
        space_d     = '0;
        ws_d        = '0;
        empty_d     = '0;
        tab_led_d   = '0;
        space_led_d = '0;
        brace_d     = '0;
        blank_d     = 1'b1;
        prior_lf_d  = 1'b0;
      end else begin
        byte_d      = byte_n;
        tab_d       = tab_n;
        space_d     = space_n;
        ws_d        = ws_n;
        empty_d     = empty_n;
        tab_led_d   = tab_led_n;
        space_led_d = space_led_n;
        brace_d     = brace_n;
        blank_d     = blank_n;
        prior_lf_d  = is_lf;
      end
    end
  end

  // State registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_q      <= '0;
      tab_q       <= '0;
      space_q     <= '0;
      ws_q        <= '0;
      empty_q     <= '0;
      tab_led_q   <= '0;
      space_led_q <= '0;
      brace_q     <= '0;
      blank_q     <= 1'b1;
      prior_lf_q  <= 1'b0;
    end else begin
      byte_q      <= byte_d;
      tab_q       <= tab_d;
      space_q     <= space_d;
      ws_q        <= ws_d;
      empty_q     <= empty_d;
      tab_led_q   <= tab_led_d;
      space_led_q <= space_led_d;
      brace_q     <= brace_d;
      blank_q     <= blank_d;
      prior_lf_q  <= prior_lf_d;
    end
  end

endmodule

/* rtl/core/slfc_queue.sv */
// Two-entry snapshot queue between the front end and the divider back end.
// Depends on slfc_pkg and the assertion macro header.
`include "source_layout_feature_counter_core_defines.svh"

module slfc_queue #(
  parameter int W = 122
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  logic [W-1:0]        push_data_i,
  input  logic                pop_i,
  output logic [W-1:0]        pop_data_o,
  output slfc_pkg::q_status_t stat_o
);

  logic [W-1:0]                  mem_q [slfc_pkg::QUEUE_DEPTH];
  logic [slfc_pkg::QPTR_W-1:0]   wr_ptr_q, wr_ptr_d;
  logic [slfc_pkg::QPTR_W-1:0]   rd_ptr_q, rd_ptr_d;
  logic [slfc_pkg::QCNT_W-1:0]   count_q, count_d;

  // Status and head entry
  assign stat_o.full      = (count_q == slfc_pkg::QCNT_W'(slfc_pkg::QUEUE_DEPTH));
  assign stat_o.not_empty = (count_q != '0);
  assign pop_data_o       = mem_q[rd_ptr_q];

  // Pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) wr_ptr_d = wr_ptr_q + slfc_pkg::QPTR_W'(1);
    if (pop_i)  rd_ptr_d = rd_ptr_q + slfc_pkg::QPTR_W'(1);
    if (push_i && !pop_i) begin
      count_d = count_q + slfc_pkg::QCNT_W'(1);
    end else if (pop_i && !push_i) begin
      count_d = count_q - slfc_pkg::QCNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Storage
  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= push_data_i;
  end

  // Checks
  `SLFC_ASSERT_NEVER(a_push_when_full, push_i && stat_o.full)
  `SLFC_ASSERT_NEVER(a_pop_when_empty, pop_i && !stat_o.not_empty)
  `SLFC_ASSERT(a_count_bound, count_q <= slfc_pkg::QCNT_W'(slfc_pkg::QUEUE_DEPTH))
  `SLFC_ASSERT(a_count_push, (push_i && !pop_i) |=> (count_q == $past(count_q) + 2'd1))

endmodule

/* rtl/core/slfc_back.sv */
// Back end: shared restoring divider that forms the four ratios of one file.
// Depends on slfc_pkg, slfc_out_if and the assertion macro header.
`include "source_layout_feature_counter_core_defines.svh"

module slfc_back #(
  parameter int COUNT_WIDTH   = 24,
  parameter int FRACTION_BITS = 16
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  slfc_pkg::q_status_t       q_stat_i,
  input  logic [5*COUNT_WIDTH+1:0]  pop_data_i,
  output logic                      q_pop_o,
  slfc_out_if.source                out_o
);

  localparam int CW     = COUNT_WIDTH;
  localparam int RW     = slfc_pkg::RATIO_W;
  localparam int STEP_W = $clog2(COUNT_WIDTH + FRACTION_BITS);
  localparam logic [STEP_W-1:0] LAST_FRAC = STEP_W'(COUNT_WIDTH + FRACTION_BITS - 1);
  localparam logic [STEP_W-1:0] LAST_WS   =
    STEP_W'(COUNT_WIDTH + slfc_pkg::WS_FRAC_BITS - 1);
  localparam logic [RW-1:0] CAP_FRAC = (FRACTION_BITS >= RW) ? {RW{1'b1}} :
                                       RW'((64'd1 << FRACTION_BITS) - 64'd1);

  slfc_pkg::back_state_e state_q, state_d;
  slfc_pkg::op_e         op_q, op_d;

  logic [CW-1:0]     byte_q, byte_d, tab_q, tab_d, space_q, space_d;
  logic [CW-1:0]     empty_q, empty_d, ws_q, ws_d;
  logic              brace_pos_q, brace_pos_d, tab_dom_q, tab_dom_d;
  logic [CW-1:0]     rem_q, rem_d, num_q, num_d;
  logic [RW-1:0]     quot_q, quot_d;
  logic              ovf_q, ovf_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic [RW-1:0]     res_q [4];
  logic [RW-1:0]     res_d [4];

  logic              out_valid_q, out_valid_d;
  logic [RW-1:0]     out_tab_q, out_space_q, out_empty_q, out_ws_q;
  logic              out_brace_q, out_dom_q, out_load;

  logic [CW-1:0]     den;
  logic [CW:0]       shifted, diff;
  logic              ge, ovf_nx, op_done;
  logic [CW-1:0]     rem_nx;
  logic [RW-1:0]     quot_nx, cap, res_val;
  logic [STEP_W-1:0] last;

  // One divider step: bring down the next dividend bit, subtract if it fits
  always_comb begin
    if (op_q == slfc_pkg::OP_WS) begin
      den  = byte_q - ws_q;
      cap  = {RW{1'b1}};
      last = LAST_WS;
    end else begin
      den  = byte_q;
      cap  = CAP_FRAC;
      last = LAST_FRAC;
    end
    shifted = {rem_q, num_q[CW-1]};
    diff    = shifted - {1'b0, den};
    ge      = (shifted >= {1'b0, den});
    rem_nx  = ge ? diff[CW-1:0] : shifted[CW-1:0];
    quot_nx = {quot_q[RW-2:0], ge};
    ovf_nx  = ovf_q | quot_q[RW-1];
    // A zero divisor (no visible bytes) gives all ones and so the cap
    res_val = (ovf_nx || (quot_nx > cap)) ? cap : quot_nx;
    op_done = (step_q == last);
  end

  assign q_pop_o  = (state_q == slfc_pkg::S_IDLE) && q_stat_i.not_empty;
  assign out_load = (state_q == slfc_pkg::S_HOLD) && (!out_valid_q || out_o.ready);

  // Sequencer
  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    byte_d      = byte_q;
    tab_d       = tab_q;
    space_d     = space_q;
    empty_d     = empty_q;
    ws_d        = ws_q;
    brace_pos_d = brace_pos_q;
    tab_dom_d   = tab_dom_q;
    rem_d       = rem_q;
    num_d       = num_q;
    quot_d      = quot_q;
    ovf_d       = ovf_q;
    step_d      = step_q;
    res_d       = res_q;
    out_valid_d = out_valid_q && !out_o.ready;
    case (state_q)
      slfc_pkg::S_IDLE: begin
        if (q_pop_o) begin
          byte_d      = pop_data_i[CW-1:0];
          tab_d       = pop_data_i[2*CW-1:CW];
          space_d     = pop_data_i[3*CW-1:2*CW];
          empty_d     = pop_data_i[4*CW-1:3*CW];
          ws_d        = pop_data_i[5*CW-1:4*CW];
          brace_pos_d = pop_data_i[5*CW];
          tab_dom_d   = pop_data_i[5*CW+1];
          op_d        = slfc_pkg::OP_TAB;
          num_d       = pop_data_i[2*CW-1:CW];
          rem_d       = '0;
          quot_d      = '0;
          ovf_d       = 1'b0;
          step_d      = '0;
          state_d     = slfc_pkg::S_DIV;
        end
      end
      slfc_pkg::S_DIV: begin
        rem_d  = rem_nx;
        num_d  = {num_q[CW-2:0], 1'b0};
        quot_d = quot_nx;
        ovf_d  = ovf_nx;
        step_d = step_q + STEP_W'(1);
        if (op_done) begin
          res_d[op_q] = res_val;
          rem_d       = '0;
          quot_d      = '0;
          ovf_d       = 1'b0;
          step_d      = '0;
          case (op_q)
            slfc_pkg::OP_TAB:   num_d = space_q;
            slfc_pkg::OP_SPACE: num_d = empty_q;
            slfc_pkg::OP_EMPTY: num_d = ws_q;
            default:            num_d = '0;
          endcase
          if (op_q == slfc_pkg::OP_WS) begin
            state_d = slfc_pkg::S_HOLD;
          end else begin
            op_d = slfc_pkg::op_e'(op_q + 2'd1);
          end
        end
      end
      slfc_pkg::S_HOLD: begin
        if (out_load) begin
          out_valid_d = 1'b1;
          state_d     = slfc_pkg::S_IDLE;
        end
      end
      default: state_d = slfc_pkg::S_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= slfc_pkg::S_IDLE;
      op_q        <= slfc_pkg::OP_TAB;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      op_q        <= op_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    byte_q      <= byte_d;
    tab_q       <= tab_d;
    space_q     <= space_d;
    empty_q     <= empty_d;
    ws_q        <= ws_d;
    brace_pos_q <= brace_pos_d;
    tab_dom_q   <= tab_dom_d;
    rem_q       <= rem_d;
    num_q       <= num_d;
    quot_q      <= quot_d;
    ovf_q       <= ovf_d;
    res_q       <= res_d;
    if (out_load) begin
      out_tab_q   <= res_q[slfc_pkg::OP_TAB];
      out_space_q <= res_q[slfc_pkg::OP_SPACE];
      out_empty_q <= res_q[slfc_pkg::OP_EMPTY];
      out_ws_q    <= res_q[slfc_pkg::OP_WS];
      out_brace_q <= brace_pos_q;
      out_dom_q   <= tab_dom_q;
    end
  end

  // Result channel
  assign out_o.valid               = out_valid_q;
  assign out_o.tab_ratio           = out_tab_q;
  assign out_o.space_ratio         = out_space_q;
  assign out_o.empty_line_ratio    = out_empty_q;
  assign out_o.whitespace_ratio    = out_ws_q;
  assign out_o.brace_own_line      = out_brace_q;
  assign out_o.tab_indent_dominant = out_dom_q;

  // Checks
  `SLFC_ASSERT(a_step_bound, (state_q == slfc_pkg::S_DIV) |-> (step_q <= LAST_FRAC))
  `SLFC_ASSERT_NEVER(a_pop_while_busy, q_pop_o && (state_q != slfc_pkg::S_IDLE))
  `SLFC_ASSERT(a_valid_from_hold, $rose(out_valid_q) |-> $past(state_q == slfc_pkg::S_HOLD))
  `SLFC_ASSERT(a_hold_after_ws, (state_q == slfc_pkg::S_HOLD) |-> (op_q == slfc_pkg::OP_WS))

endmodule
